### hw/rtl/zero_run_pixel_row_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Zero-run pixel row decoder assertion macros
// Clocked checks on clk, switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_PIXEL_ROW_DECODER_TOP_ASSERT_SVH
`define ZERO_RUN_PIXEL_ROW_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ZRPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ZRPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/zrpd_pkg.sv
// ----------------------------------------------------------------------------
// Zero-run pixel row decoder package
// Shared constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package zrpd_pkg;

	localparam int CODE_W  = 8;
	localparam int CHUNK_LEN = 8;
	localparam int DATA_W  = 64;
	localparam int PART_W  = 56;
	localparam int VB_W    = 4;
	localparam int FILL_W  = 3;
	localparam int ROW_W   = 16;
	localparam int IDX_W   = 13;
	localparam int PAD_W   = 2;
	localparam int RUN_W   = 8;

	localparam logic [ROW_W-1:0] ROW_WIDTH_MIN   = 16'd8;
	localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 16'd8;

	typedef enum logic [1:0] {
		ZRPD_IDLE,
		ZRPD_RUN,
		ZRPD_TAIL,
		ZRPD_FINISH
	} zrpd_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic tail_close;
		logic mark;
		logic finish_move;
		logic clear;
		logic cfg_open;
	} zrpd_cmd_t;

	typedef struct packed {
		logic run_empty;
		logic p_valid;
		logic o_free;
		logic end_item;
		logic row_open;
	} zrpd_sts_t;

endpackage

### hw/rtl/zrpd_ctrl.sv
// ----------------------------------------------------------------------------
// Zero-run pixel row decoder controller
// Sequences one transaction: load, byte steps, tail padding, final flush.
// ----------------------------------------------------------------------------
module zrpd_ctrl
	import zrpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  zrpd_sts_t sts,
	output zrpd_cmd_t cmd,
	output logic      in_stall
);

	zrpd_state_t state_q;
	zrpd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ZRPD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ZRPD_IDLE: begin
				in_stall     = 1'b0;
				cmd.cfg_open = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ZRPD_RUN;
				end
			end
			ZRPD_RUN: begin
				if (sts.run_empty) begin
					state_d = ZRPD_TAIL;
				end else if (!sts.p_valid || sts.o_free) begin
					cmd.step = 1'b1;
				end
			end
			ZRPD_TAIL: begin
				// close an open row at end of image
				if (sts.end_item && sts.row_open) begin
					cmd.tail_close = 1'b1;
					state_d        = ZRPD_RUN;
				end else begin
					state_d = ZRPD_FINISH;
				end
			end
			ZRPD_FINISH: begin
				if (sts.p_valid) begin
					if (sts.o_free) begin
						cmd.finish_move = 1'b1;
						cmd.clear       = sts.end_item;
						state_d         = ZRPD_IDLE;
					end
				end else if (sts.end_item) begin
					cmd.mark = 1'b1;
				end else begin
					state_d = ZRPD_IDLE;
				end
			end
			default: begin
				state_d = ZRPD_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/zrpd_dpath.sv
// ----------------------------------------------------------------------------
// Zero-run pixel row decoder datapath
// Row and chunk counters, chunk assembly, pending slot and output register.
// ----------------------------------------------------------------------------
module zrpd_dpath
	import zrpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  zrpd_cmd_t         cmd,
	output zrpd_sts_t         sts,
	input  logic [CODE_W-1:0] code_byte,
	input  logic              stream_end,
	input  logic              cfg_valid,
	input  logic [ROW_W-1:0]  cfg_data,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [DATA_W-1:0] chunk_data,
	output logic [VB_W-1:0]   valid_bytes,
	output logic [ROW_W-1:0]  row_number,
	output logic [IDX_W-1:0]  chunk_index,
	output logic              row_done,
	output logic              image_done,
	output logic              last_of_run
);

	logic [ROW_W-1:0]  row_width_q;
	logic              await_q;
	logic [ROW_W-1:0]  column_q;
	logic [FILL_W-1:0] fill_q;
	logic [PART_W-1:0] partial_q;
	logic [IDX_W-1:0]  chunk_pos_q;
	logic [ROW_W-1:0]  row_cnt_q;
	logic [RUN_W-1:0]  run_left_q;
	logic [CODE_W-1:0] byte_val_q;
	logic              end_q;
	logic              closing_q;
	logic [PAD_W-1:0]  pad_left_q;

	logic              p_valid_q;
	logic [DATA_W-1:0] p_data_q;
	logic [VB_W-1:0]   p_vb_q;
	logic [ROW_W-1:0]  p_row_q;
	logic [IDX_W-1:0]  p_idx_q;
	logic              p_rdone_q;

	logic              o_valid_q;
	logic [DATA_W-1:0] o_data_q;
	logic [VB_W-1:0]   o_vb_q;
	logic [ROW_W-1:0]  o_row_q;
	logic [IDX_W-1:0]  o_idx_q;
	logic              o_rdone_q;
	logic              o_img_q;
	logic              o_last_q;

	logic [ROW_W-1:0]  eff_w;
	logic [PAD_W-1:0]  pad_w;
	logic [ROW_W-1:0]  rem_w;
	logic [VB_W-1:0]   space;
	logic [RUN_W-1:0]  run_min;
	logic [VB_W-1:0]   n_run;
	logic [VB_W-1:0]   n_pad;
	logic [VB_W-1:0]   n_add;
	logic [VB_W-1:0]   new_fill;
	logic              px_end;
	logic              done_row;
	logic              emit;
	logic              amend;
	logic [CODE_W-1:0] fill_val;
	logic [DATA_W-1:0] chunk_base;
	logic [DATA_W-1:0] new_data;
	logic              p_load;
	logic              o_load;
	logic              o_free;

	// effective width and padding to a multiple of four
	assign eff_w = (row_width_q < ROW_WIDTH_MIN) ? ROW_WIDTH_MIN : row_width_q;
	assign pad_w = PAD_W'(2'd0 - eff_w[PAD_W-1:0]);
	assign rem_w = (column_q >= eff_w) ? ROW_W'(1) : (eff_w - column_q);

	assign space   = VB_W'(CHUNK_LEN) - {1'b0, fill_q};
	assign run_min = (run_left_q < {4'd0, space}) ? run_left_q : {4'd0, space};
	assign n_run   = ({8'd0, run_min} <= rem_w) ? run_min[VB_W-1:0] : rem_w[VB_W-1:0];
	assign n_pad   = ({2'b00, pad_left_q} < space) ? {2'b00, pad_left_q} : space;
	assign n_add   = closing_q ? n_pad : n_run;
	assign new_fill = {1'b0, fill_q} + n_add;

	assign px_end   = !closing_q && (run_left_q != '0) && ({12'd0, n_run} == rem_w);
	assign done_row = closing_q ? ({2'b00, pad_left_q} == n_pad)
	                            : (px_end && (pad_w == '0));
	assign emit     = cmd.step && (done_row ? (new_fill != '0)
	                                        : (new_fill == VB_W'(CHUNK_LEN)));
	assign amend    = cmd.step && done_row && (new_fill == '0);

	assign fill_val   = closing_q ? '0 : byte_val_q;
	assign chunk_base = {8'd0, partial_q};

	always_comb begin
		for (int i = 0; i < CHUNK_LEN; i++) begin
			if ((i >= int'(fill_q)) && (i < int'(new_fill))) begin
				new_data[i*8 +: 8] = fill_val;
			end else begin
				new_data[i*8 +: 8] = chunk_base[i*8 +: 8];
			end
		end
	end

	assign o_free = !o_valid_q || !out_stall;
	assign p_load = emit || cmd.mark;
	assign o_load = (emit && p_valid_q) || cmd.finish_move;

	assign sts.run_empty = !closing_q && (run_left_q == '0);
	assign sts.p_valid   = p_valid_q;
	assign sts.o_free    = o_free;
	assign sts.end_item  = end_q;
	assign sts.row_open  = (column_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
			await_q     <= 1'b0;
			column_q    <= '0;
			fill_q      <= '0;
			partial_q   <= '0;
			chunk_pos_q <= '0;
			row_cnt_q   <= '0;
			run_left_q  <= '0;
			end_q       <= 1'b0;
			closing_q   <= 1'b0;
			pad_left_q  <= '0;
			p_valid_q   <= 1'b0;
			o_valid_q   <= 1'b0;
		end else begin
			if (cmd.cfg_open && cfg_valid) begin
				row_width_q <= cfg_data;
			end
			if (cmd.load) begin
				end_q <= stream_end;
				if (await_q) begin
					await_q    <= 1'b0;
					run_left_q <= code_byte;
				end else if (code_byte == '0) begin
					await_q    <= 1'b1;
					run_left_q <= '0;
				end else begin
					run_left_q <= RUN_W'(1);
				end
			end
			if (cmd.step) begin
				if (closing_q) begin
					pad_left_q <= pad_left_q - n_add[PAD_W-1:0];
				end else begin
					run_left_q <= run_left_q - {4'd0, n_add};
					if (!done_row) begin
						column_q <= column_q + {12'd0, n_add};
					end
					if (px_end && (pad_w != '0)) begin
						closing_q  <= 1'b1;
						pad_left_q <= pad_w;
					end
				end
				if (done_row) begin
					column_q    <= '0;
					row_cnt_q   <= row_cnt_q + ROW_W'(1);
					chunk_pos_q <= '0;
					fill_q      <= '0;
					partial_q   <= '0;
					closing_q   <= 1'b0;
				end else if (emit) begin
					fill_q      <= '0;
					partial_q   <= '0;
					chunk_pos_q <= chunk_pos_q + IDX_W'(1);
				end else begin
					fill_q    <= new_fill[FILL_W-1:0];
					partial_q <= new_data[PART_W-1:0];
				end
			end
			if (cmd.tail_close) begin
				closing_q  <= 1'b1;
				pad_left_q <= pad_w;
			end
			if (cmd.clear) begin
				await_q     <= 1'b0;
				column_q    <= '0;
				fill_q      <= '0;
				partial_q   <= '0;
				chunk_pos_q <= '0;
				row_cnt_q   <= '0;
				closing_q   <= 1'b0;
				pad_left_q  <= '0;
			end
			if (p_load) begin
				p_valid_q <= 1'b1;
			end else if (cmd.finish_move) begin
				p_valid_q <= 1'b0;
			end
			if (o_load) begin
				o_valid_q <= 1'b1;
			end else if (!out_stall) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_val_q <= await_q ? '0 : code_byte;
		end
		if (p_load) begin
			p_data_q  <= cmd.mark ? '0 : new_data;
			p_vb_q    <= cmd.mark ? '0 : new_fill;
			p_row_q   <= row_cnt_q;
			p_idx_q   <= chunk_pos_q;
			p_rdone_q <= cmd.mark ? 1'b0 : done_row;
		end else if (amend && p_valid_q) begin
			p_rdone_q <= 1'b1;
		end
		if (o_load) begin
			o_data_q  <= p_data_q;
			o_vb_q    <= p_vb_q;
			o_row_q   <= p_row_q;
			o_idx_q   <= p_idx_q;
			o_rdone_q <= p_rdone_q;
			o_img_q   <= cmd.finish_move && end_q;
			o_last_q  <= cmd.finish_move;
		end
	end

	assign out_valid   = o_valid_q;
	assign chunk_data  = o_data_q;
	assign valid_bytes = o_vb_q;
	assign row_number  = o_row_q;
	assign chunk_index = o_idx_q;
	assign row_done    = o_rdone_q;
	assign image_done  = o_img_q;
	assign last_of_run = o_last_q;

endmodule

### hw/rtl/zero_run_pixel_row_decoder_top.sv
// ----------------------------------------------------------------------------
// Zero-run pixel row decoder top level
// Expands zero-run pixel codes into padded rows sent as tagged 8-byte chunks.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid / in_stall): one compressed byte per transaction,
//   with stream_end on the last byte of an image. A zero code followed by a
//   count byte gives that many zero pixels; any other code is one pixel.
// - Output channel (out_valid / out_stall): one chunk of up to eight row
//   bytes per transaction, tagged with row_number and chunk_index. row_done
//   closes a padded row, image_done the image, last_of_run the input item.
// - Configuration channel (cfg_valid / cfg_ready): cfg_data sets row_width;
//   cfg_ready is high only while the decoder is idle.
// Timing:
// - One transaction at a time. An item is loaded, then takes one step per
//   piece it places (a piece stops at a chunk, row, pad or run end), plus a
//   tail step to close a row at image end and a marker for the empty end.
// - Each chunk passes through a pending slot (where its flags are settled)
//   and the output register before it appears on the output.
// Reset: row_width returns to 8, all row and chunk counters clear.
// Stall: a stalled output holds its chunk; the sequencer halts while the
//   pending slot is full behind it; in_stall stays high till the item flushes.
// ----------------------------------------------------------------------------
`include "zero_run_pixel_row_decoder_top_assert.svh"

module zero_run_pixel_row_decoder_top
	import zrpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CODE_W-1:0] code_byte,
	input  logic              stream_end,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ROW_W-1:0]  cfg_data,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] chunk_data,
	output logic [VB_W-1:0]   valid_bytes,
	output logic [ROW_W-1:0]  row_number,
	output logic [IDX_W-1:0]  chunk_index,
	output logic              row_done,
	output logic              image_done,
	output logic              last_of_run
);

	zrpd_cmd_t cmd;
	zrpd_sts_t sts;

	// controller: sequence each item, hold the input while busy
	zrpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// datapath: assemble chunks, track rows, drive the output register
	zrpd_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.code_byte   (code_byte),
		.stream_end  (stream_end),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.chunk_data  (chunk_data),
		.valid_bytes (valid_bytes),
		.row_number  (row_number),
		.chunk_index (chunk_index),
		.row_done    (row_done),
		.image_done  (image_done),
		.last_of_run (last_of_run)
	);

	// accept register writes only between transactions
	assign cfg_ready = cmd.cfg_open;

	// image end always closes the item
	`ZRPD_ASSERT_IMP(a_img_last, out_valid && image_done, last_of_run,
		"image_done without last_of_run")
	// an empty chunk is only the end-of-image marker
	`ZRPD_ASSERT_IMP(a_empty_marker, out_valid && (valid_bytes == '0),
		image_done && last_of_run && !row_done, "empty chunk is not a marker")
	// the pending slot is drained before the next item is taken
	`ZRPD_ASSERT_IMP(a_idle_drained, !in_stall, !sts.p_valid,
		"pending chunk left over while idle")
	// one item at a time
	`ZRPD_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"input taken while an item is in progress")

endmodule

### bench/zero_run_pixel_row_decoder_checker.sv
// ----------------------------------------------------------------------------
// Zero-run pixel row decoder checker
// Watches the input, configuration and output channels, decodes each accepted
// code byte into the chunks it must produce and compares every output
// transaction with the oldest of those, field by field.
// ----------------------------------------------------------------------------
module zero_run_pixel_row_decoder_checker
	import zrpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [CODE_W-1:0] code_byte,
	input  logic              stream_end,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [ROW_W-1:0]  cfg_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [DATA_W-1:0] chunk_data,
	input  logic [VB_W-1:0]   valid_bytes,
	input  logic [ROW_W-1:0]  row_number,
	input  logic [IDX_W-1:0]  chunk_index,
	input  logic              row_done,
	input  logic              image_done,
	input  logic              last_of_run,
	output int                mismatches,
	output int                outstanding
);

	localparam logic [CODE_W-1:0] RUN_MARKER = '0;
	localparam int MAX_CHUNKS_PER_CODE = 64;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [VB_W-1:0]   nbytes;
		logic [ROW_W-1:0]  row;
		logic [IDX_W-1:0]  idx;
		logic              row_end;
		logic              img_end;
		logic              item_end;
	} chunk_t;

	chunk_t expected_chunks[$];
	chunk_t item_chunks[$];

	logic [ROW_W-1:0]  width_reg;
	logic              waiting_count;
	logic [ROW_W-1:0]  col;
	logic [DATA_W-1:0] gather;
	int                fill;
	logic [IDX_W-1:0]  chunk_pos;
	logic [ROW_W-1:0]  row_cnt;

	function automatic int unsigned row_pixels();
		return (width_reg < ROW_WIDTH_MIN) ? ROW_WIDTH_MIN : width_reg;
	endfunction

	function automatic void clear_image();
		waiting_count = 1'b0;
		col = '0;
		gather = '0;
		fill = 0;
		chunk_pos = '0;
		row_cnt = '0;
	endfunction

	// Chunks beyond the per-code limit are dropped and do not advance the index.
	function automatic void push_chunk(logic [DATA_W-1:0] d, int n, logic rd, logic id);
		chunk_t c;
		if (item_chunks.size() >= MAX_CHUNKS_PER_CODE)
			return;
		c = '{data: d, nbytes: VB_W'(n), row: row_cnt, idx: chunk_pos,
			row_end: rd, img_end: id, item_end: 1'b0};
		item_chunks.push_back(c);
		chunk_pos = chunk_pos + 1'b1;
	endfunction

	function automatic void flag_last_chunk(logic rd, logic id, logic ie);
		chunk_t c;
		c = item_chunks[item_chunks.size() - 1];
		c.row_end  |= rd;
		c.img_end  |= id;
		c.item_end |= ie;
		item_chunks[item_chunks.size() - 1] = c;
	endfunction

	function automatic void put_byte(logic [7:0] b);
		gather |= DATA_W'(b) << (8 * fill);
		fill++;
		if (fill >= CHUNK_LEN) begin
			push_chunk(gather, fill, 1'b0, 1'b0);
			gather = '0;
			fill = 0;
		end
	endfunction

	function automatic void close_row();
		int pad;
		pad = (4 - int'(row_pixels() % 4)) % 4;
		repeat (pad)
			put_byte('0);
		if (fill > 0) begin
			push_chunk(gather, fill, 1'b1, 1'b0);
			gather = '0;
			fill = 0;
		end else if (item_chunks.size() > 0) begin
			flag_last_chunk(1'b1, 1'b0, 1'b0);
		end
		row_cnt = row_cnt + 1'b1;
		chunk_pos = '0;
		col = '0;
	endfunction

	function automatic void place_pixel(logic [7:0] p);
		put_byte(p);
		col = col + 1'b1;
		if (col >= row_pixels())
			close_row();
	endfunction

	function automatic void decode_code(logic [CODE_W-1:0] code, logic fin);
		item_chunks.delete();
		if (waiting_count) begin
			waiting_count = 1'b0;
			repeat (code)
				place_pixel('0);
		end else if (code == RUN_MARKER) begin
			waiting_count = 1'b1;
		end else begin
			place_pixel(code);
		end
		if (fin) begin
			if (col > 0)
				close_row();
			if (item_chunks.size() > 0)
				flag_last_chunk(1'b0, 1'b1, 1'b0);
			else
				push_chunk('0, 0, 1'b0, 1'b1);
			clear_image();
		end
		if (item_chunks.size() > 0)
			flag_last_chunk(1'b0, 1'b0, 1'b1);
		foreach (item_chunks[i])
			expected_chunks.push_back(item_chunks[i]);
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		chunk_t want;
		if (!arst_n) begin
			width_reg = ROW_WIDTH_RESET;
			clear_image();
			expected_chunks.delete();
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_chunks.size() == 0) begin
					$display("%0t: chunk with nothing expected: data 0x%0h row %0d index %0d",
						$time, chunk_data, row_number, chunk_index);
					mismatches++;
				end else begin
					want = expected_chunks.pop_front();
					check_field("chunk_data", want.data, chunk_data);
					check_field("valid_bytes", DATA_W'(want.nbytes), DATA_W'(valid_bytes));
					check_field("row_number", DATA_W'(want.row), DATA_W'(row_number));
					check_field("chunk_index", DATA_W'(want.idx), DATA_W'(chunk_index));
					check_field("row_done", DATA_W'(want.row_end), DATA_W'(row_done));
					check_field("image_done", DATA_W'(want.img_end), DATA_W'(image_done));
					check_field("last_of_run", DATA_W'(want.item_end), DATA_W'(last_of_run));
				end
			end
			if (cfg_valid && cfg_ready)
				width_reg = cfg_data;
			if (in_valid && !in_stall)
				decode_code(code_byte, stream_end);
		end
		outstanding = expected_chunks.size();
	end

endmodule

### bench/zero_run_pixel_row_decoder_top_test.sv
// ----------------------------------------------------------------------------
// Zero-run pixel row decoder testbench
// Drives directed and random compressed images into the decoder under
// changing row widths and handshake pressure; a checker beside the block
// predicts every chunk and counts mismatches, and this module gives the
// verdict.
// ----------------------------------------------------------------------------
module zero_run_pixel_row_decoder_top_test;
	import zrpd_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 5;
	localparam int RANDOM_ITEMS  = 170;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [CODE_W-1:0] RUN_MARKER = '0;

	// Row widths visited by the random images, in turn: the reset value, the
	// narrow ones that are raised to eight, odd and even pad amounts, and the
	// widest row the register allows.
	localparam int NUM_WIDTHS = 9;
	localparam logic [ROW_W-1:0] WIDTHS [NUM_WIDTHS] = '{
		16'd8, 16'd0, 16'd9, 16'd13, 16'hFFFF, 16'd3, 16'd16, 16'd11, 16'd1000
	};

	// Opening image set at the reset width of eight, one {stream_end, code}
	// pair per transaction.
	localparam int NUM_OPENING = 17;
	localparam logic [CODE_W:0] OPENING [NUM_OPENING] = '{
		{1'b0, 8'hFF}, {1'b0, 8'h01}, {1'b0, 8'hAA}, {1'b0, 8'h55},  // literal extremes
		{1'b0, RUN_MARKER}, {1'b0, 8'h00},                             // empty run
		{1'b0, RUN_MARKER}, {1'b0, 8'hFF},                             // longest run
		{1'b1, 8'h7E},                                                 // stop mid-row
		{1'b1, RUN_MARKER},                                            // lone trailing zero
		{1'b0, RUN_MARKER}, {1'b0, 8'h07},
		{1'b0, RUN_MARKER}, {1'b1, 8'h01},                             // end on a full row
		{1'b1, 8'h42},                                                 // one-pixel image
		{1'b0, RUN_MARKER}, {1'b1, 8'h00}                              // empty run at end
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CODE_W-1:0] code_byte = '0;
	logic              stream_end = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ROW_W-1:0]  cfg_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATA_W-1:0] chunk_data;
	logic [VB_W-1:0]   valid_bytes;
	logic [ROW_W-1:0]  row_number;
	logic [IDX_W-1:0]  chunk_index;
	logic              row_done;
	logic              image_done;
	logic              last_of_run;

	int mismatches;
	int outstanding;
	int send_idle_pct = 28;
	int recv_idle_pct = 58;
	int codes_sent = 0;
	int cycles = 0;

	zero_run_pixel_row_decoder_top uut (.*);

	zero_run_pixel_row_decoder_checker checker_i (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Abandon the run if the decoder stops making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: stall at random on each falling edge at the current rate.
	initial begin
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Offer one code byte, idling at random first, and hold it until a rising
	// edge takes it. Return on the following falling edge with valid still high,
	// so that a back-to-back transaction replaces the payload without a gap.
	task automatic send_code(logic [CODE_W-1:0] code, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		code_byte = code;
		stream_end = fin;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		codes_sent++;
	endtask

	// Drop valid, wait for every predicted chunk, then let the decoder settle
	// for the given number of cycles.
	task automatic drain_results(int settle);
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (settle)
			@(negedge clk);
	endtask

	// Write row_width; cfg_ready only rises while the decoder is idle.
	task automatic program_width(logic [ROW_W-1:0] w);
		cfg_valid = 1'b1;
		cfg_data = w;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One random image: mostly literal pixels and marker/count pairs, with the
	// occasional image cut off on a bare run marker. Run lengths are mostly
	// short, with a few long runs that spill over many rows.
	task automatic send_image();
		int tokens;
		int pick;
		logic closing;
		logic [CODE_W-1:0] count;
		tokens = $urandom_range(1, 10);
		for (int t = 0; t < tokens; t++) begin
			closing = (t == tokens - 1);
			// Now and then hold the image until every chunk so far is out.
			if ($urandom_range(99) < 5)
				drain_results(0);
			if ($urandom_range(99) < 35) begin
				if (closing && $urandom_range(99) < 25) begin
					send_code(RUN_MARKER, 1'b1);
				end else begin
					pick = $urandom_range(99);
					count = CODE_W'((pick < 75) ? $urandom_range(0, 12) :
						(pick < 92) ? $urandom_range(13, 64) : $urandom_range(65, 255));
					send_code(RUN_MARKER, 1'b0);
					send_code(count, closing);
				end
			end else begin
				send_code(CODE_W'($urandom_range(1, 255)), closing);
			end
		end
	endtask

	initial begin
		int image_no;
		image_no = 0;

		// Hold reset for the first cycles, then release on a falling edge.
		repeat (RESET_CYCLES)
			@(negedge clk);
		arst_n = 1'b1;

		// Directed opening at the reset width.
		foreach (OPENING[i])
			send_code(OPENING[i][CODE_W-1:0], OPENING[i][CODE_W]);

		// Random images in three idling phases: sender light and receiver heavy,
		// then the other way round, then no idling at all. The row width is
		// reprogrammed before each image once the decoder has gone quiet.
		codes_sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (codes_sent < (phase + 1) * RANDOM_ITEMS / 3) begin
				drain_results(SETTLE_CYCLES);
				program_width(WIDTHS[image_no % NUM_WIDTHS]);
				image_no++;
				send_image();
			end
		end

		// Wait for the last chunks, allow time for any stray ones, and report.
		drain_results(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
